>>> hdl/elcs_pkg.sv
// shared types, constants and state codes for the edge-length cdf sampler
// no dependencies; imported by edge_length_cdf_sampler
package elcs_pkg;

  // table and coordinate sizes
  localparam int MAX_EDGES  = 1024;
  localparam int COORD_BITS = 16;

  // fixed field widths
  localparam int CHOSEN_W = 10;
  localparam int FRAC_W   = 16;
  localparam int SUM_W    = 28;

  // derived widths
  localparam int IDX_W      = $clog2(MAX_EDGES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MAG_W      = COORD_BITS + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int D2_W       = 2 * COORD_BITS + 4;
  localparam int ROOT_STEPS = D2_W / 2;
  localparam int REM_W      = ROOT_STEPS + 2;
  localparam int ADD_W      = ((SUM_W > ROOT_STEPS) ? SUM_W : ROOT_STEPS) + 1;
  localparam int PROD_W     = FRAC_W + SUM_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  // incoming word
  typedef struct packed {
    logic        [1:0]            command;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic        [FRAC_W-1:0]     uniform_fraction;
  } cmd_word_t;

  // outgoing word
  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen_edge;
    logic                table_empty;
    logic                table_overflow;
  } res_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT,
    S_WRITE,
    S_TARGET,
    S_PROBE,
    S_CMP,
    S_RESULT
  } state_t;

endpackage

>>> hdl/edge_length_cdf_sampler.sv
// edge-length cdf sampler: prefix-sum table in one synchronous memory
// depends on elcs_pkg
//
// Usage: command words arrive on cmd_valid/cmd_stall/cmd_word, results leave on
// res_valid/res_stall/res_word. A word is taken at a clock edge with valid high
// and stall low. Clear and append give no result; sample gives exactly one.
// One command is worked on at a time; cmd_stall is high while it runs.
//   clear   : done in the accept cycle
//   append  : the accept cycle, squaring through one shared multiplier, bit-pair
//             square root, then writing the running sum into the table memory;
//             an append to a full table only sets the overflow flag
//   sample  : the accept cycle, forming u times the total, then one read and one
//             compare per binary-search step (up to 11 steps, through the single
//             memory read port), then loading the result register. An empty
//             table goes from the accept straight to loading the result.
// The result register parts the two sides: a new command is accepted while a
// result still waits; a later sample holds in its final state until the
// result register is free. res_word holds steady while res_stall is high.
// Reset (rst, synchronous) empties the table and clears the overflow flag;
// the table memory itself is not cleared, only entries below the count are read.
module edge_length_cdf_sampler (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  elcs_pkg::cmd_word_t cmd_word,
  output logic                res_valid,
  input  logic                res_stall,
  output elcs_pkg::res_word_t res_word
);
  import elcs_pkg::*;

  // table memory
  logic [SUM_W-1:0] prefix_mem [MAX_EDGES];
  logic [SUM_W-1:0] rd_data;

  // control state
  state_t            state, state_next;
  logic [CNT_W-1:0]  edge_count;
  logic              overflow_seen;
  logic [SUM_W-1:0]  total;
  logic [1:0]        sq_step;
  logic [STEP_W-1:0] root_step;

  // datapath registers
  cmd_word_t          item;
  logic [SQ_W-1:0]    sq;
  logic [D2_W-1:0]    d2;
  logic [REM_W-1:0]   rem;
  logic [ROOT_STEPS-1:0] root;
  logic [PROD_W-1:0]  target;
  logic [CNT_W-1:0]   lo, hi;
  logic               samp_empty;

  // fsm outputs
  logic accept;
  logic mem_rd;
  logic mem_we;
  logic res_load;

  // handy combinational terms
  logic                   table_is_empty;
  logic                   table_full;
  logic                   res_free;
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]       mag;
  logic [REM_W-1:0]       rem_sh, trial;
  logic                   root_take;
  logic [ADD_W-1:0]       sum_wide;
  logic [SUM_W-1:0]       sum_sat;
  logic [CNT_W-1:0]       mid;
  logic                   above;
  logic [CNT_W-1:0]       lo_upd, hi_upd;
  logic [CNT_W-1:0]       pick;

  assign table_is_empty = (edge_count == '0) || (total == '0);
  assign table_full     = (edge_count == CNT_W'(MAX_EDGES));
  assign res_free       = !res_valid || !res_stall;

  // coordinate difference for the axis of this squaring step
  always_comb begin
    case (sq_step)
      2'd0:    diff = MAG_W'(item.end_x) - MAG_W'(item.start_x);
      2'd1:    diff = MAG_W'(item.end_y) - MAG_W'(item.start_y);
      default: diff = MAG_W'(item.end_z) - MAG_W'(item.start_z);
    endcase
    mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  end

  // one bit-pair step of the restoring square root
  always_comb begin
    rem_sh    = {rem[REM_W-3:0], d2[D2_W-1 -: 2]};
    trial     = {root, 2'b01};
    root_take = (rem_sh >= trial);
  end

  // saturating running sum
  always_comb begin
    sum_wide = ADD_W'(total) + ADD_W'(root);
    sum_sat  = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_wide);
  end

  // binary search step
  always_comb begin
    mid    = lo + ((hi - lo) >> 1);
    above  = ({rd_data, FRAC_W'(0)} > target);
    lo_upd = above ? lo : mid + CNT_W'(1);
    hi_upd = above ? mid : hi;
    pick   = (lo >= edge_count) ? edge_count - CNT_W'(1) : lo;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd_word.command == CMD_APPEND && !table_full) begin
            state_next = S_SQUARE;
          end else if (cmd_word.command == CMD_SAMPLE) begin
            state_next = table_is_empty ? S_RESULT : S_TARGET;
          end
        end
      end
      S_SQUARE: if (sq_step == 2'd3) state_next = S_ROOT;
      S_ROOT:   if (root_step == STEP_W'(ROOT_STEPS - 1)) state_next = S_WRITE;
      S_WRITE:  state_next = S_IDLE;
      S_TARGET: state_next = S_PROBE;
      S_PROBE:  state_next = S_CMP;
      S_CMP:    state_next = (lo_upd < hi_upd) ? S_PROBE : S_RESULT;
      S_RESULT: if (res_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    cmd_stall = 1'b1;
    mem_rd    = 1'b0;
    mem_we    = 1'b0;
    res_load  = 1'b0;
    case (state)
      S_IDLE:   cmd_stall = 1'b0;
      S_WRITE:  mem_we    = 1'b1;
      S_PROBE:  mem_rd    = 1'b1;
      S_RESULT: res_load  = res_free;
      default:  cmd_stall = 1'b1;
    endcase
  end

  assign accept = cmd_valid && !cmd_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      overflow_seen <= 1'b0;
      total         <= '0;
    end else if (accept && cmd_word.command == CMD_CLEAR) begin
      edge_count    <= '0;
      overflow_seen <= 1'b0;
      total         <= '0;
    end else if (accept && cmd_word.command == CMD_APPEND && table_full) begin
      overflow_seen <= 1'b1;
    end else if (mem_we) begin
      edge_count <= edge_count + CNT_W'(1);
      total      <= sum_sat;
    end
  end

  // step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_step   <= '0;
      root_step <= '0;
    end else begin
      sq_step   <= (state == S_SQUARE) ? sq_step + 2'd1 : 2'd0;
      root_step <= (state == S_ROOT) ? root_step + STEP_W'(1) : '0;
    end
  end

  // length datapath: squares, accumulate, square root
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd_word;
      d2   <= '0;
      rem  <= '0;
      root <= '0;
    end
    if (state == S_SQUARE) begin
      sq <= SQ_W'(mag * mag);
      if (sq_step != 2'd0) d2 <= d2 + D2_W'(sq);
    end
    if (state == S_ROOT) begin
      d2   <= {d2[D2_W-3:0], 2'b00};
      rem  <= root_take ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_STEPS-2:0], root_take};
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      lo         <= '0;
      hi         <= edge_count;
      samp_empty <= table_is_empty;
    end
    if (state == S_TARGET) target <= PROD_W'(item.uniform_fraction * total);
    if (state == S_CMP) begin
      lo <= lo_upd;
      hi <= hi_upd;
    end
  end

  // table memory write port
  always_ff @(posedge clk) begin
    if (mem_we) prefix_mem[edge_count[IDX_W-1:0]] <= sum_sat;
  end

  // table memory read port
  always_ff @(posedge clk) begin
    if (mem_rd) rd_data <= prefix_mem[mid[IDX_W-1:0]];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_word.chosen_edge    <= samp_empty ? '0 : CHOSEN_W'(pick);
      res_word.table_empty    <= samp_empty;
      res_word.table_overflow <= overflow_seen;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    edge_count <= CNT_W'(MAX_EDGES))
    else $error("edge count above table size");

  a_write_counts: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> edge_count == $past(edge_count) + CNT_W'(1))
    else $error("table write did not advance the count");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> (lo < hi) && (hi <= edge_count))
    else $error("search probe outside the filled table");

  a_empty_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.table_empty |-> res_word.chosen_edge == '0)
    else $error("empty table gave a nonzero index");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_load |-> res_free)
    else $error("result register overwritten while held");

endmodule

>>> tb/edge_length_cdf_sampler_checker.sv
// checker for the edge-length cdf sampler: watches both channels, predicts, compares
// depends on elcs_pkg; instantiated beside the block by edge_length_cdf_sampler_tb
module edge_length_cdf_sampler_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_stall,
  input  elcs_pkg::cmd_word_t cmd_word,
  input  logic                res_valid,
  input  logic                res_stall,
  input  elcs_pkg::res_word_t res_word,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import elcs_pkg::*;

  // predicted block state
  logic [SUM_W-1:0] running_sum [MAX_EDGES];
  int unsigned      edges_held;
  bit               drop_seen;
  res_word_t        draws_due [$];

  int fail_count    = 0;
  int pending_count = 0;

  assign errors  = fail_count;
  assign pending = pending_count;

  // floor of the euclidean distance between the endpoints, as an unsigned integer
  function automatic longint unsigned edge_length(cmd_word_t w);
    longint signed   dx, dy, dz;
    longint unsigned dist2, root, trial;
    dx    = longint'($signed(w.end_x)) - longint'($signed(w.start_x));
    dy    = longint'($signed(w.end_y)) - longint'($signed(w.start_y));
    dz    = longint'($signed(w.end_z)) - longint'($signed(w.start_z));
    dist2 = longint'(dx * dx + dy * dy + dz * dz);
    root  = 0;
    // bit-by-bit root, largest length fits in 18 bits
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= dist2) root = trial;
    end
    return root;
  endfunction

  // expected result word for a draw with fraction u
  function automatic res_word_t draw_for(logic [FRAC_W-1:0] u);
    res_word_t       r;
    longint unsigned total, target;
    int unsigned     pick;
    r                = '0;
    r.table_overflow = drop_seen;
    total = (edges_held == 0) ? 64'd0 : 64'(running_sum[edges_held-1]);
    if (total == 0) begin
      r.table_empty = 1'b1;
    end else begin
      target = total * 64'(u);
      pick   = edges_held - 1;
      // lowest entry whose scaled running sum is above the target
      for (int i = int'(edges_held) - 1; i >= 0; i--) begin
        if ((64'(running_sum[i]) << 16) > target) pick = i;
      end
      r.chosen_edge = CHOSEN_W'(pick);
    end
    return r;
  endfunction

  // apply one accepted command word to the predicted state
  function automatic void apply_command(cmd_word_t w);
    longint unsigned sum;
    case (w.command)
      CMD_CLEAR: begin
        edges_held = 0;
        drop_seen  = 1'b0;
      end
      CMD_APPEND: begin
        if (edges_held >= MAX_EDGES) begin
          drop_seen = 1'b1;
        end else begin
          sum = (edges_held == 0) ? 64'd0 : 64'(running_sum[edges_held-1]);
          sum = sum + edge_length(w);
          if (sum > 64'(SUM_MAX)) sum = 64'(SUM_MAX);
          running_sum[edges_held] = SUM_W'(sum);
          edges_held++;
        end
      end
      CMD_SAMPLE: draws_due = {draws_due, draw_for(w.uniform_fraction)};
      default: ;
    endcase
  endfunction

  // compare result words first, then take in the command word of this edge
  always @(posedge clk) begin
    int        bad;
    res_word_t want;
    bad = 0;
    if (rst) begin
      edges_held = 0;
      drop_seen  = 1'b0;
      draws_due.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (draws_due.size() == 0) begin
          $error("result word with no draw outstanding: chosen_edge %0d",
                 res_word.chosen_edge);
          bad++;
        end else begin
          want = draws_due.pop_front();
          if (res_word.chosen_edge !== want.chosen_edge) begin
            $error("chosen_edge: expected %0d, got %0d",
                   want.chosen_edge, res_word.chosen_edge);
            bad++;
          end
          if (res_word.table_empty !== want.table_empty) begin
            $error("table_empty: expected %0d, got %0d",
                   want.table_empty, res_word.table_empty);
            bad++;
          end
          if (res_word.table_overflow !== want.table_overflow) begin
            $error("table_overflow: expected %0d, got %0d",
                   want.table_overflow, res_word.table_overflow);
            bad++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) apply_command(cmd_word);
    end
    fail_count    <= fail_count + bad;
    pending_count <= draws_due.size();
  end

endmodule

>>> tb/edge_length_cdf_sampler_tb.sv
// top of the edge-length cdf sampler testbench: clock, reset, stimulus, verdict
// depends on elcs_pkg, edge_length_cdf_sampler and edge_length_cdf_sampler_checker
module edge_length_cdf_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import elcs_pkg::*;

  localparam int         ITEM_TARGET = 1550;
  localparam int         IDLE_LIMIT  = 1000;
  localparam int         TAIL_CYCLES = 40;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  logic      clk;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      res_stall = 1'b0;
  cmd_word_t cmd_word  = '0;
  logic      cmd_stall, res_valid;
  res_word_t res_word;

  int errors, pending;
  int words_sent  = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit steady      = 1'b0;

  edge_length_cdf_sampler i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  edge_length_cdf_sampler_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // command word with every field random
  function automatic cmd_word_t random_word(logic [1:0] cmd);
    cmd_word_t w;
    w.command          = cmd;
    w.start_x          = COORD_BITS'($urandom);
    w.start_y          = COORD_BITS'($urandom);
    w.start_z          = COORD_BITS'($urandom);
    w.end_x            = COORD_BITS'($urandom);
    w.end_y            = COORD_BITS'($urandom);
    w.end_z            = COORD_BITS'($urandom);
    w.uniform_fraction = FRAC_W'($urandom);
    return w;
  endfunction

  // append word: zero length, corners, short edges or fully random
  function automatic cmd_word_t edge_word(int unsigned style);
    cmd_word_t w;
    w = random_word(CMD_APPEND);
    case (style)
      0: begin
        w.end_x = w.start_x;
        w.end_y = w.start_y;
        w.end_z = w.start_z;
      end
      1: begin
        w.start_x = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        w.start_y = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        w.start_z = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        w.end_x   = ~w.start_x;
        w.end_y   = ~w.start_y;
        w.end_z   = ~w.start_z;
      end
      2, 3, 4: begin
        w.end_x = w.start_x + 16'($urandom_range(0, 1023)) - 16'd512;
        w.end_y = w.start_y + 16'($urandom_range(0, 1023)) - 16'd512;
        w.end_z = w.start_z + 16'($urandom_range(0, 1023)) - 16'd512;
      end
      default: ;
    endcase
    return w;
  endfunction

  // sample word: fraction zero, all ones, one half or random
  function automatic cmd_word_t sample_word(int unsigned style);
    cmd_word_t w;
    w = random_word(CMD_SAMPLE);
    case (style)
      0:       w.uniform_fraction = '0;
      1:       w.uniform_fraction = '1;
      2:       w.uniform_fraction = 16'h8000;
      default: ;
    endcase
    return w;
  endfunction

  // unless steady, hold valid low for a random gap, then present the word until it is taken
  task automatic send(cmd_word_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (w.command != CMD_NOP) words_sent++;
  endtask

  // result side: after each taken word, stall for a random stretch unless steady
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) stall_left = steady ? 0 : $urandom_range(0, 4);
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("edge_length_cdf_sampler_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int extra, appends;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, ignored code, zero total, corners, fraction extremes
    send(sample_word(3));
    send(random_word(CMD_NOP));
    send(edge_word(0));
    send(sample_word(0));
    send(edge_word(1));
    send(edge_word(0));
    send(edge_word(2));
    send(sample_word(0));
    send(sample_word(1));
    send(sample_word(2));
    send(random_word(CMD_NOP));
    send(sample_word(3));
    send(random_word(CMD_CLEAR));
    send(sample_word(0));
    send(edge_word(1));
    send(sample_word(1));
    send(sample_word(0));
    send(random_word(CMD_CLEAR));

    // fill the table past capacity, then draw with the overflow flag set
    extra = $urandom_range(1, 6);
    for (int i = 0; i < MAX_EDGES + extra; i++) begin
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      send(edge_word($urandom_range(0, 9)));
      if ($urandom_range(0, 39) == 0) send(sample_word($urandom_range(0, 9)));
    end
    repeat (8) send(sample_word($urandom_range(0, 9)));
    send(random_word(CMD_CLEAR));
    send(sample_word($urandom_range(0, 9)));

    // short build-and-draw sequences, some growing on an uncleared table
    while (words_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) send(random_word(CMD_CLEAR));
      appends = $urandom_range(0, 16);
      for (int i = 0; i < appends; i++) begin
        send(edge_word($urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) send(sample_word($urandom_range(0, 9)));
        if ($urandom_range(0, 19) == 0) send(random_word(CMD_NOP));
      end
      repeat ($urandom_range(1, 6)) send(sample_word($urandom_range(0, 9)));
    end

    // drain outstanding draws, then let the block settle
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("edge_length_cdf_sampler_tb: clean");
    end else begin
      $display("edge_length_cdf_sampler_tb: errors");
    end
    $finish;
  end

endmodule
